>>> design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define PFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pfc check failed");

// clocked check that also runs during reset
`define PFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pfc check failed");

`endif

>>> design/pfc_pkg.sv
// shared types and constants for the predictive functional control step unit
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

  localparam int MAX_HORIZON = 64;
  localparam int CNT_W       = $clog2(MAX_HORIZON + 1);
  localparam int CMP_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int POW_W       = 25;                              // q1.24 up to 1.0
  localparam int SUM_W       = $clog2(MAX_HORIZON) + POW_W;
  localparam int MA_W        = SUM_W + 3;
  localparam int MB_W        = 17;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int NUM_W       = SUM_W + 19;
  localparam int DEN_W       = SUM_W + 16;
  localparam int DVD_W       = NUM_W + 8;
  localparam int DIV_CNT_W   = $clog2(DVD_W + 1);
  localparam int V_W         = DVD_W + 1;

  typedef enum logic [2:0] {
    REG_MODEL_DECAY     = 3'd0,
    REG_MODEL_GAIN      = 3'd1,
    REG_REFERENCE_DECAY = 3'd2,
    REG_DELAY_STEPS     = 3'd3,
    REG_HORIZON_LENGTH  = 3'd4,
    REG_DRIVE_MIN       = 3'd5,
    REG_DRIVE_MAX       = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_LA, ST_LB, ST_LC,
    ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/pfc_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none
module pfc_mul import pfc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MA_W-1:0]   op_a,
  input  wire logic signed [MB_W-1:0]   op_b,
  output logic signed [PROD_W-1:0]      prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule
`default_nettype wire

>>> design/pfc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pfc_div import pfc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t  rsp
);

  logic [DEN_W:0]     rem;
  logic [DVD_W-1:0]   quo;
  logic [DEN_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic               busy;
  logic               done;
  logic [DEN_W:0]     shifted;
  logic               fits;

  assign shifted = {rem[DEN_W-1:0], quo[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dsr}) : shifted;
      quo <= {quo[DVD_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

>>> design/predictive_functional_control_step_unit.sv
// top level: sequencer around a shared multiplier and a serial divider
// sequence: model update, a pass per horizon step (P), post sums, divide, then output
// a zero denominator skips the divide
// one item at a time: in_ready is high only between items
// the result sits in an output register so the next item can start while it waits
// synchronous active-high reset: config regs to defaults, model state and last drive to zero
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module predictive_functional_control_step_unit import pfc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] target,
  input  wire logic signed [15:0] measured,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      drive,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // configuration registers
  logic [15:0]        model_decay;
  logic signed [15:0] model_gain;
  logic [15:0]        reference_decay;
  logic [6:0]         delay_steps;
  logic [6:0]         horizon_length;
  logic signed [15:0] drive_min;
  logic signed [15:0] drive_max;

  // controller state
  logic signed [15:0] model_output;
  logic signed [15:0] last_drive;

  // per-item working registers
  state_t             state, state_next;
  logic signed [15:0] sp, y, x;
  logic [POW_W-1:0]   pa, pr;
  logic [SUM_W-1:0]   spa, spr;
  logic [CNT_W-1:0]   j, n, p;
  logic signed [NUM_W-1:0] num;
  logic               neg;
  logic signed [V_W-1:0]   v;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (state == ST_IDLE);

  pfc_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));
  pfc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // model update rounding: divide by 2^24, half away from zero, saturate to 16 bits
  logic signed [NUM_W-1:0] mdl_sum;
  logic [NUM_W-1:0]        mdl_mag;
  logic [NUM_W-1:0]        mdl_rnd;
  logic signed [NUM_W-23:0] mdl_q;
  logic signed [15:0]      mdl_x;
  always_comb begin
    mdl_sum = num + NUM_W'(prod);
    mdl_mag = mdl_sum[NUM_W-1] ? NUM_W'(-mdl_sum) : NUM_W'(mdl_sum);
    mdl_rnd = mdl_mag + NUM_W'(24'h800000);
    mdl_q   = $signed({2'b00, mdl_rnd[NUM_W-1:24]});
    if (mdl_sum[NUM_W-1]) mdl_q = -mdl_q;
    if (mdl_q > (NUM_W-22)'(32767)) mdl_x = 16'sh7fff;
    else if (mdl_q < -(NUM_W-22)'(32768)) mdl_x = -16'sh8000;
    else mdl_x = mdl_q[15:0];
  end

  // power update: (p * factor + 2^15) >> 16
  logic [POW_W+16:0] pw_sum;
  logic [POW_W-1:0]  pow_new;
  assign pw_sum  = {1'b0, prod[POW_W+15:0]} + (POW_W+17)'(32768);
  assign pow_new = pw_sum[POW_W+15:16];

  // dead-time window check for the current step
  logic in_window;
  assign in_window = CMP_W'(j) >= (CMP_W'(delay_steps) + CMP_W'(1));

  // denominator and dividend set-up
  logic [PROD_W-1:0] den_mag;
  logic [NUM_W-1:0]  num_mag;
  assign den_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // final clamp, drive_min tested first; when the limits cross, drive_min wins only below it
  logic signed [V_W-1:0] vmin, vmax;
  logic signed [15:0]    v_clamped;
  assign vmin = V_W'(drive_min);
  assign vmax = V_W'(drive_max);
  always_comb begin
    priority if (v < vmin) v_clamped = drive_min;
    else if (v > vmax)     v_clamped = drive_max;
    else                   v_clamped = v[15:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = (p == '0) ? ST_P1 : ST_LA;
      ST_LA:   state_next = ST_LB;
      ST_LB:   state_next = ST_LC;
      ST_LC:   state_next = (j == p) ? ST_P1 : ST_LA;
      ST_P1:   state_next = ST_P2;
      ST_P2:   state_next = ST_P3;
      ST_P3:   state_next = ST_P4;
      ST_P4:   state_next = ST_P5;
      ST_P5:   state_next = (prod == '0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (drsp.done) state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select and divider start
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dreq.start    = 1'b0;
    dreq.dividend = DVD_W'({num_mag, 8'b0}) + DVD_W'(den_mag[DEN_W-1:1]);
    dreq.divisor  = den_mag[DEN_W-1:0];
    unique case (state)
      ST_M1: begin
        mul_a = MA_W'($signed({1'b0, model_decay}));
        mul_b = MB_W'(model_output);
      end
      ST_M2: begin
        // 1.0 - a stays positive, so it needs 18 bits signed
        mul_a = MA_W'($signed(18'h10000 - {2'b00, model_decay}));
        mul_b = MB_W'(last_drive);
      end
      ST_M3: begin
        mul_a = MA_W'(prod);
        mul_b = MB_W'(model_gain);
      end
      ST_LA: begin
        mul_a = MA_W'($signed({1'b0, pa}));
        mul_b = $signed({1'b0, model_decay});
      end
      ST_LB: begin
        mul_a = MA_W'($signed({1'b0, pr}));
        mul_b = $signed({1'b0, reference_decay});
      end
      ST_P1: begin
        mul_a = MA_W'(18'(sp) - 18'(y) + 18'(x));
        mul_b = MB_W'($signed({1'b0, n}));
      end
      ST_P2: begin
        mul_a = MA_W'($signed({1'b0, spr}));
        mul_b = MB_W'(17'(sp) - 17'(y));
      end
      ST_P3: begin
        mul_a = MA_W'($signed({1'b0, spa}));
        mul_b = MB_W'(x);
      end
      ST_P4: begin
        // gain sum: n * 1.0 - sum of a^j
        mul_a = MA_W'($signed({1'b0, n})) <<< 24;
        mul_a = mul_a - MA_W'($signed({1'b0, spa}));
        mul_b = MB_W'(model_gain);
      end
      ST_P5: dreq.start = (prod != '0);
      default: ;
    endcase
  end

  // configuration writes, ignored beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      model_decay     <= '0;
      model_gain      <= 16'sd256;
      reference_decay <= '0;
      delay_steps     <= '0;
      horizon_length  <= 7'd16;
      drive_min       <= -16'sd4096;
      drive_max       <= 16'sd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODEL_DECAY:     model_decay     <= cfg_data;
        REG_MODEL_GAIN:      model_gain      <= cfg_data;
        REG_REFERENCE_DECAY: reference_decay <= cfg_data;
        REG_DELAY_STEPS:     delay_steps     <= cfg_data[6:0];
        REG_HORIZON_LENGTH:  horizon_length  <= cfg_data[6:0];
        REG_DRIVE_MIN:       drive_min       <= cfg_data;
        REG_DRIVE_MAX:       drive_max       <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      model_output <= '0;
      last_drive   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_M4) model_output <= mdl_x;
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        last_drive <= v_clamped;
      end else if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: if (in_xfer) begin
        sp <= target;
        y  <= measured;
        // horizon saturates at the maximum
        if (CMP_W'(horizon_length) > CMP_W'(MAX_HORIZON)) p <= CNT_W'(MAX_HORIZON);
        else p <= CNT_W'(horizon_length);
      end
      ST_M2: num <= NUM_W'(prod) <<< 8;
      ST_M4: begin
        x   <= mdl_x;
        pa  <= POW_W'(1) << 24;
        pr  <= POW_W'(1) << 24;
        spa <= '0;
        spr <= '0;
        j   <= CNT_W'(1);
        n   <= '0;
      end
      ST_LB: pa <= pow_new;
      ST_LC: begin
        pr <= pow_new;
        if (in_window) begin
          spa <= spa + SUM_W'(pa);
          spr <= spr + SUM_W'(pow_new);
          n   <= n + 1'b1;
        end
        j <= j + 1'b1;
      end
      ST_P2: num <= NUM_W'(prod) <<< 24;
      ST_P3: num <= num - NUM_W'(prod);
      ST_P4: num <= num - NUM_W'(prod);
      ST_P5: begin
        neg <= num[NUM_W-1] ^ prod[PROD_W-1];
        // zero denominator: saturate toward the numerator's sign, or keep the last drive if it is zero
        if (prod == '0) begin
          priority if (num > 0) v <= V_W'(drive_max);
          else if (num < 0)     v <= V_W'(drive_min);
          else                  v <= V_W'(last_drive);
        end
      end
      ST_DIV: if (drsp.done) begin
        v <= neg ? -$signed({1'b0, drsp.quotient}) : $signed({1'b0, drsp.quotient});
      end
      ST_OUT: if (!out_valid || out_ready) drive <= v_clamped;
      default: ;
    endcase
  end

  // checks
  logic drive_ok;
  assign drive_ok = (drive >= drive_min) && (drive <= drive_max);

  `PFC_ASSERT(a_busy_after_accept, in_xfer |=> !in_ready)
  `PFC_ASSERT(a_div_only_in_div, drsp.done |-> state == ST_DIV)
  `PFC_ASSERT(a_drive_in_limits, (out_valid && drive_min <= drive_max) |-> drive_ok)

endmodule
`default_nettype wire
